FILE: rtl/aes_ctr_pkg.sv
// Package with payload types, constants and an AES helper function.
package aes_ctr_pkg;

    localparam int unsigned BlockBytes = 16;
    localparam int unsigned AesRounds  = 10;
    localparam int unsigned NonceBytes = 13;
    localparam logic [8:0]  AesPoly    = 9'h11B;

    localparam logic [2:0] RegKeyHigh = 3'd0;
    localparam logic [2:0] RegKeyLow  = 3'd1;
    localparam logic [2:0] RegIvHigh  = 3'd2;
    localparam logic [2:0] RegIvLow   = 3'd3;
    localparam logic [2:0] RegMode    = 3'd4;

    localparam logic OpStart = 1'b0;
    localparam logic OpData  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_in;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } out_item_t;

    // Queue entry between the front and back parts.
    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] gf_double(input logic [7:0] v);
        logic [8:0] w;
        begin
            w = {v, 1'b0};
            if (v[7])
            begin
                w = w ^ AesPoly;
            end
            return w[7:0];
        end
    endfunction

endpackage

FILE: rtl/aes_ctr_front.sv
// Front part: accepts items and holds them in a two-entry queue.
module aes_ctr_front
    import aes_ctr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Classify and store the item.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{start: (in_item.op == OpStart),
                                   data: in_item.data_in, last: in_item.last_byte};
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/aes_ctr_back.sv
// Back part: round-key expansion, one AES round per cycle and the byte XOR.
module aes_ctr_back
    import aes_ctr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [127:0]  key,
    input  logic [127:0]  iv,
    input  logic          mode,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cmd_t          cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output out_item_t     out_item
);

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StExpand = 2'd1;
    localparam logic [1:0] StCrypt  = 2'd2;

    logic [1:0]   state_reg;
    logic [3:0]   round_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] rk_reg [11];
    logic [127:0] ctr_reg;
    logic [127:0] st_reg;
    logic [127:0] ks_reg;
    logic [4:0]   pos_reg;
    logic         out_valid_reg;
    out_item_t    out_reg;

    logic [127:0] next_rk;
    logic [127:0] round_out;
    logic [127:0] sb;
    logic [127:0] mc;
    logic [127:0] ccm_ctr;
    logic [7:0]   ks_byte;
    logic         out_free;
    logic         need_block;

    // Byte k of a word sits at bits 127-8k downto 120-8k.
    always_comb
    begin
        logic [31:0] w3;
        logic [31:0] t;
        logic [31:0] w [4];
        logic [127:0] prev;
        prev = rk_reg[round_reg];
        w3   = prev[31:0];
        t    = {SBOX[w3[23:16]] ^ rcon_reg, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w[0] = prev[127:96] ^ t;
        w[1] = prev[95:64] ^ w[0];
        w[2] = prev[63:32] ^ w[1];
        w[3] = prev[31:0] ^ w[2];
        next_rk = {w[0], w[1], w[2], w[3]};
    end

    // Sub bytes and shift rows, then mix columns (not in the last round) and the round key.
    always_comb
    begin
        logic [7:0] a, b, d, e, all;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[127 - 8 * (4 * c + r) -: 8] =
                    SBOX[st_reg[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a   = sb[127 - 32 * c -: 8];
            b   = sb[119 - 32 * c -: 8];
            d   = sb[111 - 32 * c -: 8];
            e   = sb[103 - 32 * c -: 8];
            all = a ^ b ^ d ^ e;
            mc[127 - 32 * c -: 32] = {a ^ all ^ gf_double(a ^ b), b ^ all ^ gf_double(b ^ d),
                                      d ^ all ^ gf_double(d ^ e), e ^ all ^ gf_double(e ^ a)};
        end
        round_out = ((round_reg == 4'(AesRounds)) ? sb : mc) ^ rk_reg[round_reg];
    end

    assign ccm_ctr    = {8'h01, iv[127:24], 8'h00, 8'h01};
    assign ks_byte    = ks_reg[127 - 8 * pos_reg[3:0] -: 8];
    assign out_free   = !out_valid_reg || out_ready;
    assign need_block = pos_reg[4];
    assign cmd_ready  = (state_reg == StIdle) && out_free
                        && (cmd.start || !need_block);
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;

    // Round-key store: the key is loaded on a start item, then one round key a cycle during expansion.
    always_ff @(posedge clk)
    begin
        if (state_reg == StIdle && cmd_valid && cmd.start && out_free)
        begin
            rk_reg[0] <= key;
        end
        else if (state_reg == StExpand)
        begin
            rk_reg[round_reg + 4'd1] <= next_rk;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == StIdle && cmd_valid && !cmd.start && need_block)
        begin
            st_reg <= ctr_reg ^ rk_reg[0];
        end
        else if (state_reg == StCrypt)
        begin
            st_reg <= round_out;
            if (round_reg == 4'(AesRounds))
            begin
                ks_reg <= round_out;
            end
        end
        if (cmd_valid && cmd_ready && !cmd.start)
        begin
            out_reg <= '{data_out: cmd.data ^ ks_byte, last_out: cmd.last};
        end
    end

    // Control sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            round_reg     <= 4'd0;
            rcon_reg      <= 8'h01;
            ctr_reg       <= '0;
            pos_reg       <= 5'(BlockBytes);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                StIdle:
                begin
                    if (cmd_valid && cmd_ready && cmd.start)
                    begin
                        ctr_reg   <= mode ? ccm_ctr : iv;
                        pos_reg   <= 5'(BlockBytes);
                        round_reg <= 4'd0;
                        rcon_reg  <= 8'h01;
                        state_reg <= StExpand;
                    end
                    else if (cmd_valid && cmd_ready)
                    begin
                        pos_reg       <= pos_reg + 5'd1;
                        out_valid_reg <= 1'b1;
                    end
                    else if (cmd_valid && !cmd.start && need_block)
                    begin
                        round_reg <= 4'd1;
                        state_reg <= StCrypt;
                    end
                end
                StExpand:
                begin
                    rcon_reg <= gf_double(rcon_reg);
                    if (round_reg == 4'(AesRounds - 1))
                    begin
                        round_reg <= 4'd0;
                        state_reg <= StIdle;
                    end
                    else
                    begin
                        round_reg <= round_reg + 4'd1;
                    end
                end
                StCrypt:
                begin
                    if (round_reg == 4'(AesRounds))
                    begin
                        ctr_reg   <= ctr_reg + 128'd1;
                        pos_reg   <= 5'd0;
                        round_reg <= 4'd0;
                        state_reg <= StIdle;
                    end
                    else
                    begin
                        round_reg <= round_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= StIdle;
                end
            endcase
        end
    end

endmodule

FILE: rtl/aes128_ctr_keystream_cipher.sv
// Top level of the AES-128 counter-mode byte cipher.
//
// Input channel (in_valid/in_ready/in_item): op 0 is a start item that
// samples key, IV and counter mode, expands the round keys and loads the
// counter block; it gives no result. Op 1 is a data byte that is XORed
// with the next keystream byte and gives one result on the output
// channel (out_valid/out_ready/out_item), last_out echoing last_byte.
// A two-entry queue decouples acceptance from the cipher engine.
// A data byte that finds keystream left passes the queue and the result
// register. The first data byte after a start item, and every sixteenth
// one from then on, first runs the counter block through ten AES rounds,
// one round per cycle on a single round unit; no byte is taken meanwhile.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at the next
// start item. Reset clears the configuration and control registers and marks the keystream used up.
// A stalled receiver holds the result register; the queue then fills and
// in_ready drops.
module aes128_ctr_keystream_cipher
    import aes_ctr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] iv_high_reg;
    logic [63:0] iv_low_reg;
    logic        mode_reg;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_t        cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegKeyHigh: key_high_reg <= cfg_data;
                RegKeyLow:  key_low_reg  <= cfg_data;
                RegIvHigh:  iv_high_reg  <= cfg_data;
                RegIvLow:   iv_low_reg   <= cfg_data;
                RegMode:    mode_reg     <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    aes_ctr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    aes_ctr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .iv        ({iv_high_reg, iv_low_reg}),
        .mode      (mode_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // A start item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.start) |=> !$rose(out_valid))
        else $error("start item produced a result");

    // A data item taken from the queue yields a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && !cmd.start) |=> out_valid)
        else $error("data item lost");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");
`endif

endmodule
